[src/rct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants for the rank correlation block
// widths of samples, counts and the store, and the sequencer states
// ----------------------------------------------------------------------------
package rct_pkg;
	localparam int MaxSamples  = 1024;
	localparam int SampleWidth = 32;
	localparam int AddrWidth   = $clog2(MaxSamples);
	localparam int CountWidth  = AddrWidth + 1;
	localparam int AccWidth    = 20;
	localparam int OutCntWidth = 19;
	localparam int SumWidth    = AccWidth + 1;
	localparam int ProdWidth   = 2 * SumWidth;
	localparam int TauWidth    = 16;
	localparam int QWidth      = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_TAU,
		ST_OUT
	} rct_state_t;

	// tally of one compare, one-hot or zero
	typedef struct packed {
		logic conc;
		logic disc;
		logic tie_x;
		logic tie_y;
	} rct_tally_t;
endpackage

[src/rct_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_ram: generic single-port synchronous ram
// one access per cycle, a write also reads the old word; read data registered
// ----------------------------------------------------------------------------
module rct_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// registered read, write in place
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[src/rct_tau.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_tau: tau magnitude by bit-serial search
// finds largest q with (2q-1)^2 * p <= (65536*a)^2, one bit at a time from the top
// ----------------------------------------------------------------------------
module rct_tau (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rct_pkg::SumWidth-1:0]     a,
	input  logic [rct_pkg::ProdWidth-1:0]    p,
	output logic                             done,
	output logic [rct_pkg::QWidth-1:0]       q
);
	import rct_pkg::*;

	localparam int TWidth   = QWidth + 1;
	localparam int T2Width  = 2 * TWidth;
	localparam int PPWidth  = T2Width + SumWidth;
	localparam int LWidth   = T2Width + ProdWidth;
	localparam int RWidth   = SumWidth + 16;
	localparam int R2Width  = 2 * RWidth;
	localparam int ASqWidth = 2 * SumWidth;

	// steps of one bit
	localparam logic [1:0] PhSquare  = 2'd0;
	localparam logic [1:0] PhLow     = 2'd1;
	localparam logic [1:0] PhHigh    = 2'd2;
	localparam logic [1:0] PhCompare = 2'd3;

	logic [QWidth-1:0]      q_q;
	logic [4:0]             bit_q;
	logic                   busy_q;
	logic [1:0]             phase_q;
	logic [T2Width-1:0]     tsq_q;
	logic [R2Width-1:0]     rsq_q;
	logic [ProdWidth-1:0]   p_q;
	logic [LWidth-1:0]      lhs_q;
	logic [QWidth-1:0]      cand;
	logic [TWidth-1:0]      t;
	logic [SumWidth-1:0]    p_half;
	logic [PPWidth-1:0]     pp;

	// candidate sets the current bit; the top bit has value 32768
	assign cand = q_q | (QWidth'(1) << bit_q[3:0]);
	assign t    = {cand, 1'b0} - TWidth'(1);

	// one shared multiplier, low half of p then high half
	assign p_half = (phase_q == PhLow) ? p_q[SumWidth-1:0] : p_q[ProdWidth-1:SumWidth];
	assign pp     = PPWidth'(tsq_q) * PPWidth'(p_half);

	// square, two partial products, then compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PhSquare;
			bit_q   <= '0;
			q_q     <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= PhSquare;
				bit_q   <= 5'd15;
				q_q     <= '0;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == PhCompare) begin
					if (lhs_q <= LWidth'(rsq_q)) begin
						q_q <= cand;
					end
					if (bit_q == 5'd0) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
			end
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (start) begin
			p_q   <= p;
			rsq_q <= {ASqWidth'(a) * ASqWidth'(a), 32'd0};
		end
		if (busy_q) begin
			case (phase_q)
				PhSquare: tsq_q <= T2Width'(t) * T2Width'(t);
				PhLow:    lhs_q <= LWidth'(pp);
				PhHigh:   lhs_q <= lhs_q + (LWidth'(pp) << SumWidth);
				default:  ;
			endcase
		end
	end

	// search never exceeds 32768 when a * a <= p
	assign q = q_q;

	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("tau done while busy");
	ap_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("search not started");
	ap_bit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bit_q <= 5'd15) else $error("bit index out of range");
endmodule

[src/rank_correlation_tau.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_correlation_tau: streaming kendall tau-b
// compares each pair with all stored pairs from ram until the store is full, emits counts and tau
// ----------------------------------------------------------------------------
// channel   dir  fields (lsb first)
// s_axis    in   tdata: sample_x[31:0], sample_y[63:32]; tlast: last_pair
// m_axis    out  tdata: tau_q15, concordant, discordant, ties_x, ties_y
//                tuser: undefined
//
// an item with n stored pairs makes one ram read per stored pair
// a last item goes on to the tau search and then posts the result
// reset clears counts and the fill count; the store itself is never cleared
// a held result blocks all requests until it is taken
// ----------------------------------------------------------------------------
module rank_correlation_tau (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // sample_x, sample_y
	input  logic         s_axis_tlast,   // last_pair
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // tau_q15, conc, disc, ties_x, ties_y, pad
	output logic         m_axis_tuser    // undefined
);
	import rct_pkg::*;

	rct_state_t state_q, state_d;

	logic [SampleWidth-1:0] kx_q, ky_q;
	logic                   last_q;
	logic [CountWidth-1:0]  count_q;
	logic [AddrWidth-1:0]   idx_q;
	logic                   rd_valid_s1;
	logic [AccWidth-1:0]    conc_q, disc_q, tx_q, ty_q;
	logic [SampleWidth-1:0] ox, oy;
	logic                   we;
	logic [AddrWidth-1:0]   addr;
	rct_tally_t             tally;
	logic                   accept;
	logic                   full;
	logic                   tau_start, tau_done;
	logic [QWidth-1:0]      q;
	logic [SumWidth-1:0]    a, sx, sy;
	logic [ProdWidth-1:0]   p;
	logic                   neg;
	logic [TauWidth-1:0]    tau_val;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign full   = count_q[AddrWidth];
	assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;

	// ram address: read while scanning, write the new pair at the end
	assign we   = (state_q == ST_FLUSH) && !full;
	assign addr = we ? count_q[AddrWidth-1:0] : idx_q;

	rct_ram #(.Width(SampleWidth), .Depth(MaxSamples)) u_ram_x (
		.clk, .we, .addr, .wdata(kx_q), .rdata(ox));
	rct_ram #(.Width(SampleWidth), .Depth(MaxSamples)) u_ram_y (
		.clk, .we, .addr, .wdata(ky_q), .rdata(oy));

	// compare against one stored pair
	always_comb begin
		tally = '0;
		if (rd_valid_s1) begin
			if (kx_q == ox && ky_q != oy) begin
				tally.tie_x = 1'b1;
			end else if (kx_q != ox && ky_q == oy) begin
				tally.tie_y = 1'b1;
			end else if (kx_q != ox && ky_q != oy) begin
				if ((kx_q > ox) == (ky_q > oy)) begin
					tally.conc = 1'b1;
				end else begin
					tally.disc = 1'b1;
				end
			end
		end
	end

	// tau operands
	assign sx  = SumWidth'(conc_q) + SumWidth'(disc_q) + SumWidth'(tx_q);
	assign sy  = SumWidth'(conc_q) + SumWidth'(disc_q) + SumWidth'(ty_q);
	assign neg = disc_q > conc_q;
	assign a   = neg ? SumWidth'(disc_q - conc_q) : SumWidth'(conc_q - disc_q);
	assign p   = ProdWidth'(sx) * ProdWidth'(sy);
	assign tau_start = (state_q == ST_FLUSH) && last_q;

	rct_tau u_tau (.clk, .arst_n, .start(tau_start), .a, .p, .done(tau_done), .q);

	assign tau_val = neg ? TauWidth'(17'h10000 - 17'(q))
		: ((q > 16'd32767) ? 16'd32767 : q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SCAN;
			ST_SCAN:  if (full || idx_q == count_q[AddrWidth-1:0]) state_d = ST_FLUSH;
			ST_FLUSH: state_d = last_q ? ST_TAU : ST_IDLE;
			ST_TAU:   if (tau_done) state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			idx_q         <= '0;
			rd_valid_s1   <= 1'b0;
			conc_q        <= '0;
			disc_q        <= '0;
			tx_q          <= '0;
			ty_q          <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			rd_valid_s1 <= (state_q == ST_SCAN) && !full
				&& (idx_q != count_q[AddrWidth-1:0]);
			if (state_q == ST_SCAN && idx_q != count_q[AddrWidth-1:0]) begin
				idx_q <= idx_q + AddrWidth'(1);
			end
			if (accept) begin
				idx_q <= '0;
			end
			if (state_q == ST_OUT) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tuser  <= (p == '0);
				m_axis_tdata  <= {4'd0, ty_q[OutCntWidth-1:0], tx_q[OutCntWidth-1:0],
					disc_q[OutCntWidth-1:0], conc_q[OutCntWidth-1:0],
					(p == '0) ? 16'd0 : tau_val};
				count_q <= '0;
				conc_q  <= '0;
				disc_q  <= '0;
				tx_q    <= '0;
				ty_q    <= '0;
			end else begin
				conc_q <= conc_q + AccWidth'(tally.conc);
				disc_q <= disc_q + AccWidth'(tally.disc);
				tx_q   <= tx_q + AccWidth'(tally.tie_x);
				ty_q   <= ty_q + AccWidth'(tally.tie_y);
				if (we) begin
					count_q <= count_q + CountWidth'(1);
				end
			end
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kx_q   <= s_axis_tdata[31:0] ^ 32'h8000_0000;
			ky_q   <= s_axis_tdata[63:32] ^ 32'h8000_0000;
			last_q <= s_axis_tlast;
		end
	end

	ap_one_tally: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tally)) else $error("more than one tally per compare");
	ap_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountWidth'(MaxSamples)) else $error("store overfilled");
	ap_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> m_axis_tvalid && count_q == '0)
		else $error("result not posted");
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for rank_correlation_tau
// streams data sets of (x, y) pairs into the block, keeps its own model of the
// pair counts and the q1.15 tau-b, and checks every result field by field
// ----------------------------------------------------------------------------
module tb_top;
	import rct_pkg::*;

	localparam int CycleLimit = 4000000;

	typedef struct packed {
		logic signed [TauWidth-1:0] tau;
		logic [OutCntWidth-1:0]     conc;
		logic [OutCntWidth-1:0]     disc;
		logic [OutCntWidth-1:0]     ties_x;
		logic [OutCntWidth-1:0]     ties_y;
		logic                       undef;
	} tau_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	// model of the pairs of the open data set and its tallies
	logic signed [SampleWidth-1:0] set_x[$];
	logic signed [SampleWidth-1:0] set_y[$];
	int unsigned conc_acc, disc_acc, tie_x_acc, tie_y_acc;
	tau_result_t pending_results[$];

	int unsigned cycles;
	int unsigned errors;
	int unsigned pairs_sent;
	int unsigned sets_checked;
	bit          no_gaps;

	rank_correlation_tau uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("** rank_correlation_tau: FAILED **");
			$finish;
		end
	end

	// gap length: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (no_gaps || $urandom_range(0, 99) < 70) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
		end
	end

	// exact tau-b search: largest q with (2q-1)^2 * p <= (65536*a)^2
	function automatic tau_result_t tau_of_set();
		tau_result_t res;
		logic [63:0]  c, d, a, p;
		logic [127:0] lhs, rhs, t;
		int unsigned  lo, hi, mid;
		c = conc_acc;
		d = disc_acc;
		p = (c + d + tie_x_acc) * (c + d + tie_y_acc);
		res.conc   = conc_acc[OutCntWidth-1:0];
		res.disc   = disc_acc[OutCntWidth-1:0];
		res.ties_x = tie_x_acc[OutCntWidth-1:0];
		res.ties_y = tie_y_acc[OutCntWidth-1:0];
		res.undef  = (p == 0);
		res.tau    = '0;
		if (p != 0) begin
			a = (d > c) ? d - c : c - d;
			rhs = 128'(a << 16) * 128'(a << 16);
			lo = 0;
			hi = 32768;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				t = 128'(2 * mid - 1);
				lhs = t * t * 128'(p);
				if (lhs <= rhs) lo = mid;
				else hi = mid - 1;
			end
			if (d > c) res.tau = 16'(65536 - lo);
			else res.tau = (lo > 32767) ? 16'sd32767 : 16'(lo);
		end
		return res;
	endfunction

	// fold one accepted pair into the model
	task automatic tally_pair(input logic signed [31:0] x, input logic signed [31:0] y,
	                          input bit last);
		bit ex, ey;
		if (set_x.size() < MaxSamples) begin
			foreach (set_x[j]) begin
				ex = (x == set_x[j]);
				ey = (y == set_y[j]);
				if (ex && !ey) tie_x_acc++;
				else if (!ex && ey) tie_y_acc++;
				else if (!ex && !ey) begin
					if ((x > set_x[j]) == (y > set_y[j])) conc_acc++;
					else disc_acc++;
				end
			end
			set_x.push_back(x);
			set_y.push_back(y);
		end
		if (last) begin
			pending_results.push_back(tau_of_set());
			set_x.delete();
			set_y.delete();
			conc_acc = 0;
			disc_acc = 0;
			tie_x_acc = 0;
			tie_y_acc = 0;
		end
	endtask

	// send one request and wait for it to be taken
	task automatic send_pair(input logic signed [31:0] x, input logic signed [31:0] y,
	                         input bit last);
		int unsigned gap;
		gap = no_gaps ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		pairs_sent++;
		tally_pair(x, y, last);
	endtask

	// result checker
	always @(posedge clk) begin
		tau_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.tau    = m_axis_tdata[15:0];
			got.conc   = m_axis_tdata[34:16];
			got.disc   = m_axis_tdata[53:35];
			got.ties_x = m_axis_tdata[72:54];
			got.ties_y = m_axis_tdata[91:73];
			got.undef  = m_axis_tuser;
			if (pending_results.size() == 0) begin
				$display("%t: result with none expected: tdata=%h tuser=%b",
				         $realtime, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				sets_checked++;
				if (got.tau !== want.tau) begin
					$display("%t: tau_q15 expected %0d actual %0d", $realtime,
					         want.tau, got.tau);
					errors++;
				end
				if (got.conc !== want.conc) begin
					$display("%t: concordant expected %0d actual %0d", $realtime,
					         want.conc, got.conc);
					errors++;
				end
				if (got.disc !== want.disc) begin
					$display("%t: discordant expected %0d actual %0d", $realtime,
					         want.disc, got.disc);
					errors++;
				end
				if (got.ties_x !== want.ties_x) begin
					$display("%t: ties_x expected %0d actual %0d", $realtime,
					         want.ties_x, got.ties_x);
					errors++;
				end
				if (got.ties_y !== want.ties_y) begin
					$display("%t: ties_y expected %0d actual %0d", $realtime,
					         want.ties_y, got.ties_y);
					errors++;
				end
				if (got.undef !== want.undef) begin
					$display("%t: undefined expected %b actual %b", $realtime,
					         want.undef, got.undef);
					errors++;
				end
			end
		end
	end

	// extremes, ties, single pair, perfect order and reverse order
	task automatic test_directed();
		send_pair(32'sh7fffffff, 32'sh80000000, 1'b1);
		send_pair(5, 5, 1'b0);
		send_pair(5, 5, 1'b1);
		send_pair(32'sh80000000, 32'sh80000000, 1'b0);
		send_pair(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_pair(0, 0, 1'b0);
		send_pair(-1, -1, 1'b1);
		send_pair(32'sh80000000, 32'sh7fffffff, 1'b0);
		send_pair(32'sh7fffffff, 32'sh80000000, 1'b0);
		send_pair(0, 1, 1'b1);
		send_pair(3, 1, 1'b0);
		send_pair(3, 2, 1'b0);
		send_pair(7, 2, 1'b0);
		send_pair(-4, 9, 1'b1);
		send_pair(1, 1, 1'b0);
		send_pair(2, 1, 1'b0);
		send_pair(3, 1, 1'b1);
		send_pair(1, 1, 1'b0);
		send_pair(1, 2, 1'b0);
		send_pair(1, 3, 1'b1);
	endtask

	// random sets of small size, mixing narrow ranges for ties, correlated mid ranges and full range
	task automatic test_random();
		int unsigned n, span;
		logic signed [31:0] x, y;
		while (pairs_sent < 570) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			span = $urandom_range(0, 2);
			no_gaps = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < n; i++) begin
				case (span)
					0: begin
						x = $urandom_range(0, 3);
						y = $urandom_range(0, 3);
					end
					1: begin
						x = $urandom_range(0, 200) - 100;
						y = ($urandom_range(0, 1) ? x : -x) + $urandom_range(0, 20);
					end
					default: begin
						x = $urandom();
						y = $urandom();
					end
				endcase
				send_pair(x, y, i == n - 1);
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cycles        = 0;
		errors        = 0;
		pairs_sent    = 0;
		sets_checked  = 0;
		no_gaps       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (pending_results.size() != 0) errors++;

		$display("sent %0d pairs, checked %0d data sets of ties, extremes and random pairs",
		         pairs_sent, sets_checked);
		if (errors == 0) begin
			$display("** rank_correlation_tau: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** rank_correlation_tau: FAILED **");
		end
		$finish;
	end
endmodule

[rank_correlation_tau.f]
src/rct_pkg.sv
src/rct_ram.sv
src/rct_tau.sv
src/rank_correlation_tau.sv
bench/tb_top.sv
